### src/sfcs_pkg.sv
// ----------------------------------------------------------------------------
// sfcs_pkg
// Shared types, constants and the crc-8 step for the sensor frame decoder.
// ----------------------------------------------------------------------------
package sfcs_pkg;

  // crc-8 parameters, msb first, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // byte positions inside one six-byte frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // scaling constants: spans and offset in hundredths, raw full scale in counts
  localparam logic [14:0] TEMP_SPAN_CENTI   = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET_CENTI = 16'd4500;
  localparam logic [13:0] HUM_SPAN_CENTI    = 14'd10000;
  localparam logic [15:0] RAW_FULL_SCALE    = 16'hFFFF;

  // legal result ranges
  localparam logic signed [14:0] TEMP_MIN_CENTI = -15'sd4500;
  localparam logic signed [14:0] TEMP_MAX_CENTI = 15'sd13000;
  localparam logic [13:0]        HUM_MAX_CENTI  = 14'd10000;

  // one decoded frame waiting to be scaled
  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
    logic        crc_ok;
  } sfcs_job_t;

  // queue status seen by the front, the back and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } sfcs_qstat_t;

  // crc-8 over one byte, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### src/sfcs_front.sv
// ----------------------------------------------------------------------------
// sfcs_front
// Tracks the byte position, runs the crc checks and assembles raw words;
// hands one job per complete frame to the queue.
// ----------------------------------------------------------------------------
module sfcs_front
  import sfcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  input  sfcs_qstat_t q_stat,
  output logic        q_push,
  output sfcs_job_t   q_job
);

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] raw_temp_r, raw_temp_nxt;
  logic [15:0] raw_hum_r, raw_hum_nxt;
  logic        temp_good_r, temp_good_nxt;

  logic        accept;
  logic [2:0]  pos;
  logic [7:0]  crc_seed;
  logic [7:0]  crc_calc;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // resync on frame start or an out-of-range position
  assign pos      = (in_frame_start || pos_r > POS_H_CRC) ? POS_T_MSB : pos_r;
  assign crc_seed = (pos == POS_T_MSB || pos == POS_H_MSB) ? CRC_INIT : crc_r;
  assign crc_calc = crc8_byte(crc_seed, in_data_byte);

  // per-position update
  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    raw_temp_nxt  = raw_temp_r;
    raw_hum_nxt   = raw_hum_r;
    temp_good_nxt = temp_good_r;
    q_push        = 1'b0;
    q_job.raw_temp = raw_temp_r;
    q_job.raw_hum  = raw_hum_r;
    q_job.crc_ok   = temp_good_r && (crc_r == in_data_byte);
    if (accept) begin
      pos_nxt = (pos >= POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
      unique case (pos)
        POS_T_MSB: begin
          crc_nxt      = crc_calc;
          raw_temp_nxt = {in_data_byte, 8'h00};
        end
        POS_T_LSB: begin
          crc_nxt      = crc_calc;
          raw_temp_nxt = {raw_temp_r[15:8], in_data_byte};
        end
        POS_T_CRC: begin
          temp_good_nxt = (crc_r == in_data_byte);
          crc_nxt       = CRC_INIT;
        end
        POS_H_MSB: begin
          crc_nxt     = crc_calc;
          raw_hum_nxt = {in_data_byte, 8'h00};
        end
        POS_H_LSB: begin
          crc_nxt     = crc_calc;
          raw_hum_nxt = {raw_hum_r[15:8], in_data_byte};
        end
        default: begin
          crc_nxt = CRC_INIT;
          q_push  = 1'b1;
        end
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_T_MSB;
      crc_r       <= CRC_INIT;
      raw_temp_r  <= '0;
      raw_hum_r   <= '0;
      temp_good_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      raw_temp_r  <= raw_temp_nxt;
      raw_hum_r   <= raw_hum_nxt;
      temp_good_r <= temp_good_nxt;
    end
  end

endmodule

### src/sfcs_queue.sv
// ----------------------------------------------------------------------------
// sfcs_queue
// Small fifo of decoded frames between the front and the scaling back end.
// ----------------------------------------------------------------------------
module sfcs_queue
  import sfcs_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sfcs_job_t   wr_job,
  input  logic        pop,
  output sfcs_job_t   rd_job,
  output sfcs_qstat_t stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sfcs_job_t     slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_job     = slots_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

### src/sfcs_back.sv
// ----------------------------------------------------------------------------
// sfcs_back
// Scales raw words to hundredths in two stages and holds the last good values
// in the output register.
// ----------------------------------------------------------------------------
module sfcs_back
  import sfcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sfcs_qstat_t        q_stat,
  input  sfcs_job_t          q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_temperature_centi,
  output logic        [13:0] out_humidity_centi,
  output logic               out_crc_ok
);

  // floor(x / 65535) for x below 2^31 with quotient well below 65535
  function automatic logic [15:0] div_full_scale(input logic [31:0] x);
    logic [15:0] q;
    logic [16:0] s;
    q = x[31:16];
    s = {1'b0, q} + {1'b0, x[15:0]};
    return q + 16'(s >= {1'b0, RAW_FULL_SCALE});
  endfunction

  logic        mul_valid_r, mul_valid_nxt;
  logic        mul_ok_r;
  logic [30:0] prod_temp_r;
  logic [29:0] prod_hum_r;

  logic        out_valid_r, out_valid_nxt;
  logic [14:0] temp_r, temp_nxt;
  logic [13:0] hum_r, hum_nxt;
  logic        ok_r, ok_nxt;

  logic        out_load_ok;
  logic        out_load;
  logic        mul_adv;
  logic [15:0] temp_div;
  logic [15:0] hum_div;
  logic [15:0] temp_centi;

  assign out_load_ok = !out_valid_r || out_ready;
  assign out_load    = mul_valid_r && out_load_ok;
  assign mul_adv     = !mul_valid_r || out_load_ok;
  assign q_pop       = mul_adv && !q_stat.empty;

  // stage one: constant multiplies
  assign mul_valid_nxt = mul_adv ? !q_stat.empty : mul_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= mul_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mul_ok_r    <= q_job.crc_ok;
      prod_temp_r <= 31'(q_job.raw_temp) * 31'(TEMP_SPAN_CENTI);
      prod_hum_r  <= 30'(q_job.raw_hum) * 30'(HUM_SPAN_CENTI);
    end
  end

  // stage two: divide by full scale, offset, hold on crc failure
  assign temp_div   = div_full_scale({1'b0, prod_temp_r});
  assign hum_div    = div_full_scale({2'b00, prod_hum_r});
  assign temp_centi = temp_div - TEMP_OFFSET_CENTI;

  always_comb begin
    temp_nxt      = temp_r;
    hum_nxt       = hum_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = mul_ok_r;
      if (mul_ok_r) begin
        temp_nxt = temp_centi[14:0];
        hum_nxt  = hum_div[13:0];
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // output register doubles as the held good values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      temp_r      <= '0;
      hum_r       <= '0;
      ok_r        <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      temp_r      <= temp_nxt;
      hum_r       <= hum_nxt;
      ok_r        <= ok_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = $signed(temp_r);
  assign out_humidity_centi    = hum_r;
  assign out_crc_ok            = ok_r;

endmodule

### src/sensor_frame_crc_scaler.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_scaler
// Six-byte sensor frame decoder: crc-8 check and scaling to hundredths.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle while the queue is not full. The sixth byte of a
// frame yields one result beat through the queue write, the multiply stage and
// the output register; new bytes are taken while earlier frames are scaled.
// A stalled output fills the queue, and the input stalls only once it is full.
// Synchronous active-low reset clears position, crc, held values and queue.
module sensor_frame_crc_scaler
  import sfcs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_temperature_centi,
  output logic        [13:0] out_humidity_centi,
  output logic               out_crc_ok
);

  sfcs_qstat_t q_stat;
  sfcs_job_t   push_job;
  sfcs_job_t   pop_job;
  logic        q_push;
  logic        q_pop;

  // front: byte position, crc, raw words
  sfcs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  // frame queue
  sfcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (push_job),
    .pop    (q_pop),
    .rd_job (pop_job),
    .stat   (q_stat)
  );

  // back: scaling and output register
  sfcs_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_stat                (q_stat),
    .q_job                 (pop_job),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_crc_ok            (out_crc_ok)
  );

`ifndef SYNTHESIS
  // no write into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("frame pushed into full queue");

  // no read from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("frame popped from empty queue");

  // scaled values stay within the sensor range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_centi >= TEMP_MIN_CENTI
                   && out_temperature_centi <= TEMP_MAX_CENTI
                   && out_humidity_centi <= HUM_MAX_CENTI))
    else $error("scaled value out of range");

  // a failed frame leaves the held values untouched
  a_hold_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && !out_crc_ok |->
      $stable(out_temperature_centi) && $stable(out_humidity_centi))
    else $error("held values changed on crc failure");
`endif

endmodule

### verif/sfcs_frame_checker.sv
// ----------------------------------------------------------------------------
// sfcs_frame_checker
// Watches both channels of the sensor frame decoder, predicts every reading
// from the accepted byte beats and compares each result beat field by field.
// ----------------------------------------------------------------------------
module sfcs_frame_checker
  import sfcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_start,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [14:0] out_temperature_centi,
  input  logic        [13:0] out_humidity_centi,
  input  logic               out_crc_ok,
  output int                 error_count,
  output int                 readings_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // one expected reading
  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic        [13:0] hum_centi;
    logic               crc_ok;
  } reading_t;

  reading_t expected_readings[$];
  int       errors  = 0;
  int       pending = 0;

  // decoder state mirror
  logic [2:0]  frame_slot;
  logic [7:0]  crc_acc;
  logic [15:0] raw_temp;
  logic [15:0] raw_hum;
  logic        temp_crc_good;
  logic [14:0] held_temp;
  logic [13:0] held_hum;

  assign error_count      = errors;
  assign readings_pending = pending;

  // crc-8 0x31, one data bit per step, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ data[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  // advance the frame decoder by one byte, queue a reading on the last byte
  task automatic decode_frame_byte(input logic [7:0] b, input logic start);
    logic [2:0] slot;
    logic       ok;
    longint     scaled;
    reading_t   r;
    slot = frame_slot;
    if (start || slot > POS_H_CRC) begin
      slot    = POS_T_MSB;
      crc_acc = CRC_INIT;
    end
    case (slot)
      POS_T_MSB: begin
        crc_acc  = crc8_step(CRC_INIT, b);
        raw_temp = {b, 8'h00};
      end
      POS_T_LSB: begin
        crc_acc       = crc8_step(crc_acc, b);
        raw_temp[7:0] = b;
      end
      POS_T_CRC: begin
        temp_crc_good = (crc_acc == b);
        crc_acc       = CRC_INIT;
      end
      POS_H_MSB: begin
        crc_acc = crc8_step(CRC_INIT, b);
        raw_hum = {b, 8'h00};
      end
      POS_H_LSB: begin
        crc_acc      = crc8_step(crc_acc, b);
        raw_hum[7:0] = b;
      end
      default: begin
        ok = temp_crc_good && (crc_acc == b);
        if (ok) begin
          scaled    = (longint'(TEMP_SPAN_CENTI) * longint'(raw_temp)) / longint'(RAW_FULL_SCALE)
                      - longint'(TEMP_OFFSET_CENTI);
          held_temp = scaled[14:0];
          scaled    = (longint'(HUM_SPAN_CENTI) * longint'(raw_hum)) / longint'(RAW_FULL_SCALE);
          held_hum  = scaled[13:0];
        end
        r.temp_centi = held_temp;
        r.hum_centi  = held_hum;
        r.crc_ok     = ok;
        expected_readings.push_back(r);
        crc_acc = CRC_INIT;
      end
    endcase
    frame_slot = (slot >= POS_H_CRC) ? POS_T_MSB : slot + 3'd1;
  endtask

  // compare result beats first, then predict from the input beat
  always @(posedge clk) begin
    reading_t want;
    logic     bad;
    if (!rst_n) begin
      frame_slot    = POS_T_MSB;
      crc_acc       = CRC_INIT;
      raw_temp      = '0;
      raw_hum       = '0;
      temp_crc_good = 1'b0;
      held_temp     = '0;
      held_hum      = '0;
      expected_readings.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: temp %0d hum %0d crc_ok %0b",
                   $time, out_temperature_centi, out_humidity_centi, out_crc_ok);
        end else begin
          want = expected_readings.pop_front();
          bad  = 1'b0;
          if (out_temperature_centi !== want.temp_centi) begin
            bad = 1'b1;
            $display("%0t: temperature_centi expected %0d actual %0d",
                     $time, want.temp_centi, out_temperature_centi);
          end
          if (out_humidity_centi !== want.hum_centi) begin
            bad = 1'b1;
            $display("%0t: humidity_centi expected %0d actual %0d",
                     $time, want.hum_centi, out_humidity_centi);
          end
          if (out_crc_ok !== want.crc_ok) begin
            bad = 1'b1;
            $display("%0t: crc_ok expected %0b actual %0b", $time, want.crc_ok, out_crc_ok);
          end
          if (bad) errors++;
        end
      end
      if (in_valid && in_ready) begin
        decode_frame_byte(in_data_byte, in_frame_start);
      end
    end
    pending = expected_readings.size();
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for the sensor frame decoder: directed frames covering bad crc
// before any good frame, raw extremes, resync and wrap without frame_start,
// then random frames, broken frames and noise under varying idle and stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte   = 8'h00;
  logic               in_frame_start = 1'b0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic signed [14:0] out_temperature_centi;
  logic        [13:0] out_humidity_centi;
  logic               out_crc_ok;

  int error_count;
  int readings_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sensor_frame_crc_scaler dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_frame_start       (in_frame_start),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_temperature_centi(out_temperature_centi),
    .out_humidity_centi   (out_humidity_centi),
    .out_crc_ok           (out_crc_ok)
  );

  sfcs_frame_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_frame_start       (in_frame_start),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_temperature_centi(out_temperature_centi),
    .out_humidity_centi   (out_humidity_centi),
    .out_crc_ok           (out_crc_ok),
    .error_count          (error_count),
    .readings_pending     (readings_pending)
  );

  // crc-8 0x31 over a data pair, built to form good frames
  function automatic logic [7:0] pair_crc(input logic [15:0] word);
    logic [7:0] acc;
    acc = 8'hFF;
    for (int i = 15; i >= 0; i--) begin
      acc = {acc[6:0], 1'b0} ^ ((acc[7] ^ word[i]) ? 8'h31 : 8'h00);
    end
    return acc;
  endfunction

  // raw word with extra weight on the scale ends
  function automatic logic [15:0] pick_raw();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // one input beat, with a random gap ahead of it; entered at a falling edge
  task automatic send_beat(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid       = 1'b0;
      in_data_byte   = 8'($urandom);
      in_frame_start = 1'($urandom);
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_data_byte   = b;
    in_frame_start = start;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // first nbytes of a frame; bad flags corrupt the matching crc byte
  task automatic send_frame(input logic [15:0] rt, input logic [15:0] rh, input logic t_bad,
                            input logic h_bad, input logic start, input int nbytes);
    logic [7:0] fb[6];
    fb[0] = rt[15:8];
    fb[1] = rt[7:0];
    fb[2] = pair_crc(rt) ^ (t_bad ? 8'($urandom_range(1, 255)) : 8'h00);
    fb[3] = rh[15:8];
    fb[4] = rh[7:0];
    fb[5] = pair_crc(rh) ^ (h_bad ? 8'($urandom_range(1, 255)) : 8'h00);
    for (int i = 0; i < nbytes; i++) begin
      send_beat(fb[i], (i == 0) ? start : 1'b0);
    end
  endtask

  // receiver stalls
  initial begin
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("sensor_frame_crc_scaler regression: fail");
    $finish;
  end

  // stimulus
  initial begin
    int   idle_by_phase[4];
    int   stall_by_phase[4];
    int   kind;
    int   n;
    int   target;
    logic need_start;
    logic t_bad;
    idle_by_phase  = '{0, 72, 0, 23};
    stall_by_phase = '{0, 0, 72, 23};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // bad crc before any good frame reports the reset values
    send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b1, 6);
    // good frame continuing after the wrap without frame_start
    send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6);
    // partial frame dropped by a resync
    send_frame(16'hFF00, 16'h00FF, 1'b0, 1'b0, 1'b1, 1);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1, 6);
    // humidity crc bad only keeps the last good values
    send_frame(pick_raw(), pick_raw(), 1'b0, 1'b1, 1'b1, 6);

    need_start = 1'b0;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      target         = bytes_sent + 410;
      while (bytes_sent < target) begin
        kind = $urandom_range(99);
        if (kind < 60) begin
          send_frame(pick_raw(), pick_raw(), 1'b0, 1'b0,
                     need_start || ($urandom_range(3) != 0), 6);
          need_start = 1'b0;
        end else if (kind < 75) begin
          t_bad = 1'($urandom);
          send_frame(pick_raw(), pick_raw(), t_bad, t_bad ? 1'($urandom) : 1'b1,
                     need_start || ($urandom_range(3) != 0), 6);
          need_start = 1'b0;
        end else if (kind < 88) begin
          // broken frame, the next one resyncs
          send_frame(pick_raw(), pick_raw(), 1'b0, 1'b0, 1'b1, $urandom_range(1, 5));
          need_start = 1'b1;
        end else begin
          // noise with stray frame_start
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            send_beat(8'($urandom), $urandom_range(9) == 0);
          end
          need_start = 1'b1;
        end
      end
    end
    in_valid = 1'b0;

    // drain, then let the pipeline settle
    while (readings_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0 && readings_pending == 0) begin
      $display("sensor_frame_crc_scaler regression: pass");
    end else begin
      $display("sensor_frame_crc_scaler regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
src/sfcs_pkg.sv
src/sfcs_front.sv
src/sfcs_queue.sv
src/sfcs_back.sv
src/sensor_frame_crc_scaler.sv
verif/sfcs_frame_checker.sv
verif/tb_top.sv
